@@ sv/rpnc_pkg.sv @@
// Shared types, codes and constants of the RPN calculator core.
package rpnc_pkg;

    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int ST_W        = 3;
    localparam int DEPTH_OUT_W = 3;
    localparam int DEPTH_DEF   = 7;
    localparam int FRAC_DEF    = 16;
    localparam int ITERS       = 32;
    localparam int ITER_W      = 5;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd1;
    localparam logic [ST_W-1:0] ST_UNDER = 3'd2;
    localparam logic [ST_W-1:0] ST_SAT   = 3'd3;
    localparam logic [ST_W-1:0] ST_DIVZ  = 3'd4;

    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                     start;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] s;
        logic signed [DATA_W-1:0] t;
    } t_alu_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] res;
        logic                     sat;
        logic                     divz;
    } t_alu_rsp;

endpackage

@@ sv/rpnc_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one calculator command.
interface rpnc_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [rpnc_pkg::OP_W-1:0]            op;
    logic signed [rpnc_pkg::DATA_W-1:0]   push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

@@ sv/rpnc_res_if.sv @@
// Result channel: valid/ready handshake carrying status, depth and top of stack.
interface rpnc_res_if;
    logic                                   valid;
    logic                                   ready;
    logic [rpnc_pkg::ST_W-1:0]              status;
    logic [rpnc_pkg::DEPTH_OUT_W-1:0]       depth;
    logic signed [rpnc_pkg::DATA_W-1:0]     top_value;

    modport source (output valid, output status, output depth, output top_value, input ready);
    modport sink   (input valid, input status, input depth, input top_value, output ready);
endinterface

@@ sv/rpnc_stack.sv @@
// Operand stack storage: one write port, one registered read port.
module rpnc_stack #(
    parameter int DEPTH = rpnc_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [rpnc_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [rpnc_pkg::DATA_W-1:0] o_rdata
);

    logic signed [rpnc_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [rpnc_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rpnc_alu.sv @@
// Iterative arithmetic unit: add/sub in one step, shift-add multiply, restoring divide.
module rpnc_alu #(
    parameter int FRAC_BITS = rpnc_pkg::FRAC_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpnc_pkg::t_alu_req i_req,
    output rpnc_pkg::t_alu_rsp o_rsp
);

    localparam int DW = rpnc_pkg::DATA_W;

    localparam logic [2:0] A_IDLE  = 3'd0;
    localparam logic [2:0] A_SETUP = 3'd1;
    localparam logic [2:0] A_LOOP  = 3'd2;
    localparam logic [2:0] A_FIX   = 3'd3;
    localparam logic [2:0] A_FIN   = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [rpnc_pkg::OP_W-1:0]   r_op, n_op;
    logic signed [DW-1:0]        r_s, n_s;
    logic signed [DW-1:0]        r_t, n_t;
    logic [DW-1:0]               r_ma, n_ma;
    logic [DW-1:0]               r_mb, n_mb;
    logic                        r_neg, n_neg;
    logic [DW-1:0]               r_hi, n_hi;
    logic [DW-1:0]               r_lo, n_lo;
    logic [rpnc_pkg::ITER_W-1:0] r_cnt, n_cnt;
    logic                        r_done, n_done;
    logic signed [DW-1:0]        r_res, n_res;
    logic                        r_sat, n_sat;
    logic                        r_divz, n_divz;

    logic                        is_div;
    logic [DW+1:0]               base, addend, sum;
    logic                        ge;
    logic [DW:0]                 sum_as;
    logic [2*DW-1:0]             numer;
    logic signed [2*DW-1:0]      prod_sh;
    logic                        ovf;

    // Shared adder: shift-add for multiply, trial subtract for divide.
    always_comb begin
        is_div = (r_op == rpnc_pkg::OP_DIV);
        if (is_div) begin
            base   = {1'b0, r_hi, r_lo[DW-1]};
            addend = ~{2'b00, r_mb};
        end else begin
            base   = {2'b00, r_hi};
            addend = r_lo[0] ? {2'b00, r_ma} : '0;
        end
        sum = base + addend + {{(DW+1){1'b0}}, is_div};
        ge  = ~sum[DW+1];
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_s     = r_s;
        n_t     = r_t;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_neg   = r_neg;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_res   = r_res;
        n_sat   = r_sat;
        n_divz  = r_divz;
        sum_as  = '0;
        numer   = '0;
        prod_sh = '0;
        ovf     = 1'b0;

        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_op    = i_req.op;
                    n_s     = i_req.s;
                    n_t     = i_req.t;
                    n_ma    = i_req.s[DW-1] ? DW'(-i_req.s) : DW'(i_req.s);
                    n_mb    = i_req.t[DW-1] ? DW'(-i_req.t) : DW'(i_req.t);
                    n_neg   = i_req.s[DW-1] ^ i_req.t[DW-1];
                    n_sat   = 1'b0;
                    n_divz  = 1'b0;
                    n_state = A_SETUP;
                end
            end
            A_SETUP: begin
                case (r_op)
                    rpnc_pkg::OP_ADD, rpnc_pkg::OP_SUB: begin
                        if (r_op == rpnc_pkg::OP_ADD) begin
                            sum_as = {r_s[DW-1], r_s} + {r_t[DW-1], r_t};
                        end else begin
                            sum_as = {r_s[DW-1], r_s} - {r_t[DW-1], r_t};
                        end
                        ovf     = sum_as[DW] != sum_as[DW-1];
                        n_sat   = ovf;
                        n_res   = ovf ? (sum_as[DW] ? rpnc_pkg::VAL_MIN : rpnc_pkg::VAL_MAX)
                                      : sum_as[DW-1:0];
                        n_done  = 1'b1;
                        n_state = A_IDLE;
                    end
                    rpnc_pkg::OP_MUL: begin
                        n_hi    = '0;
                        n_lo    = r_mb;
                        n_cnt   = '0;
                        n_state = A_LOOP;
                    end
                    default: begin
                        numer = (2*DW)'(r_ma) << FRAC_BITS;
                        if (r_t == '0) begin
                            n_divz  = 1'b1;
                            n_res   = r_s[DW-1] ? rpnc_pkg::VAL_MIN
                                    : (r_s == '0) ? '0 : rpnc_pkg::VAL_MAX;
                            n_done  = 1'b1;
                            n_state = A_IDLE;
                        end else if (numer[2*DW-1:DW] >= r_mb) begin
                            // Quotient needs more than 32 bits: clamp now.
                            n_sat   = 1'b1;
                            n_res   = r_neg ? rpnc_pkg::VAL_MIN : rpnc_pkg::VAL_MAX;
                            n_done  = 1'b1;
                            n_state = A_IDLE;
                        end else begin
                            n_hi    = numer[2*DW-1:DW];
                            n_lo    = numer[DW-1:0];
                            n_cnt   = '0;
                            n_state = A_LOOP;
                        end
                    end
                endcase
            end
            A_LOOP: begin
                if (is_div) begin
                    n_hi = ge ? sum[DW-1:0] : base[DW-1:0];
                    n_lo = {r_lo[DW-2:0], ge};
                end else begin
                    n_hi = sum[DW:1];
                    n_lo = {sum[0], r_lo[DW-1:1]};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rpnc_pkg::ITER_W'(rpnc_pkg::ITERS - 1)) begin
                    n_state = is_div ? A_FIN : A_FIX;
                end
            end
            A_FIX: begin
                if (r_neg) begin
                    {n_hi, n_lo} = (2*DW)'(-{r_hi, r_lo});
                end
                n_state = A_FIN;
            end
            A_FIN: begin
                if (is_div) begin
                    if (!r_neg) begin
                        n_sat = r_lo[DW-1];
                        n_res = n_sat ? rpnc_pkg::VAL_MAX : r_lo;
                    end else begin
                        n_sat = r_lo > rpnc_pkg::VAL_MIN;
                        n_res = n_sat ? rpnc_pkg::VAL_MIN : DW'(-r_lo);
                    end
                end else begin
                    // Arithmetic shift rounds toward minus infinity.
                    prod_sh = $signed({r_hi, r_lo}) >>> FRAC_BITS;
                    ovf     = !((&prod_sh[2*DW-1:DW-1]) || !(|prod_sh[2*DW-1:DW-1]));
                    n_sat   = ovf;
                    n_res   = ovf ? (prod_sh[2*DW-1] ? rpnc_pkg::VAL_MIN : rpnc_pkg::VAL_MAX)
                                  : prod_sh[DW-1:0];
                end
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_s    <= n_s;
        r_t    <= n_t;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_neg  <= n_neg;
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
        r_sat  <= n_sat;
        r_divz <= n_divz;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.divz = r_divz;

endmodule

@@ sv/rpn_stack_calculator_core.sv @@
// RPN calculator core: command sequencer, stack bookkeeping and result register.
//
// Usage: commands arrive on i_cmd (op, push_value) under valid/ready; each one
// gives exactly one beat on o_res (status, depth, top_value). The stack holds
// up to DEPTH Q-format entries; the top entry is cached in a register and the
// entry beneath it is read from the stack memory through its registered port.
// Push, underflow and unused codes finish without the arithmetic unit; add,
// subtract, and divide when the quotient clamps early or the divisor is zero,
// finish in its setup step; multiply and divide otherwise run the 32 one-bit
// iterations of the shared shift-add/subtract unit. i_cmd.ready is high only
// while the sequencer is idle, so one command is in work at a time; the next
// command beat can come in the cycle after the result is loaded. The result
// register holds a finished beat while the receiver stalls; the next command
// is still taken, and its result waits in the sequencer until the result
// register is free. Reset (i_rst_n low at a clock edge) empties the stack and
// drops any pending result; the stack memory itself is not cleared, since
// entries above the count are never used.
module rpn_stack_calculator_core #(
    parameter int DEPTH     = rpnc_pkg::DEPTH_DEF,
    parameter int FRAC_BITS = rpnc_pkg::FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpnc_cmd_if.sink    i_cmd,
    rpnc_res_if.source  o_res
);

    localparam int DW = rpnc_pkg::DATA_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_ALU  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [rpnc_pkg::OP_W-1:0] r_op, n_op;
    logic signed [DW-1:0]      r_pv, n_pv;
    logic [CW-1:0]             r_count, n_count;
    logic signed [DW-1:0]      r_top, n_top;
    logic [rpnc_pkg::ST_W-1:0] r_status, n_status;

    logic                             r_ovalid, n_ovalid;
    logic [rpnc_pkg::ST_W-1:0]        r_ostatus, n_ostatus;
    logic [rpnc_pkg::DEPTH_OUT_W-1:0] r_odepth, n_odepth;
    logic signed [DW-1:0]             r_otop, n_otop;

    logic                 cmd_acc;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [DW-1:0] wdata;
    logic [AW-1:0]        raddr;
    logic signed [DW-1:0] second;

    rpnc_pkg::t_alu_req alu_req;
    rpnc_pkg::t_alu_rsp alu_rsp;

    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    // Entry beneath the top; only used when the count is two or more.
    assign raddr       = AW'(r_count - CW'(2));

    rpnc_stack #(.DEPTH(DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (second)
    );

    rpnc_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_pv      = r_pv;
        n_count   = r_count;
        n_top     = r_top;
        n_status  = r_status;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_odepth  = r_odepth;
        n_otop    = r_otop;
        we        = 1'b0;
        waddr     = raddr;
        wdata     = alu_rsp.res;
        alu_req.start = 1'b0;
        alu_req.op    = r_op;
        alu_req.s     = second;
        alu_req.t     = r_top;

        if (r_ovalid && o_res.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_op    = i_cmd.op;
                    n_pv    = i_cmd.push_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (r_op == rpnc_pkg::OP_PUSH) begin
                    if (r_count < CW'(DEPTH)) begin
                        we       = 1'b1;
                        waddr    = AW'(r_count);
                        wdata    = r_pv;
                        n_count  = r_count + 1'b1;
                        n_top    = r_pv;
                        n_status = rpnc_pkg::ST_OK;
                    end else begin
                        n_status = rpnc_pkg::ST_FULL;
                    end
                end else if (r_op inside {rpnc_pkg::OP_ADD, rpnc_pkg::OP_SUB,
                                          rpnc_pkg::OP_MUL, rpnc_pkg::OP_DIV}) begin
                    if (r_count < CW'(2)) begin
                        // A lone entry is consumed and lost.
                        n_count  = '0;
                        n_status = rpnc_pkg::ST_UNDER;
                    end else begin
                        alu_req.start = 1'b1;
                        n_state       = S_ALU;
                    end
                end else begin
                    n_status = rpnc_pkg::ST_OK;
                end
            end
            S_ALU: begin
                if (alu_rsp.done) begin
                    we       = 1'b1;
                    n_count  = r_count - 1'b1;
                    n_top    = alu_rsp.res;
                    n_status = alu_rsp.divz ? rpnc_pkg::ST_DIVZ
                             : alu_rsp.sat  ? rpnc_pkg::ST_SAT : rpnc_pkg::ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the result register is free.
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_odepth  = rpnc_pkg::DEPTH_OUT_W'(r_count);
                    n_otop    = (r_count != '0) ? r_top : '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pv      <= n_pv;
        r_top     <= n_top;
        r_status  <= n_status;
        r_ostatus <= n_ostatus;
        r_odepth  <= n_odepth;
        r_otop    <= n_otop;
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.status    = r_ostatus;
    assign o_res.depth     = r_odepth;
    assign o_res.top_value = r_otop;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("stack count above depth");

    a_alu_done_in_alu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == S_ALU))
        else $error("arithmetic unit finished outside its wait state");

    a_accept_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> $stable(r_count))
        else $error("stack count moved on the command beat");

    a_load_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !o_res.ready) |=> (r_state == S_DONE))
        else $error("result dropped while receiver stalled");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the RPN stack calculator core: directed and random commands.
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_CMDS = 2000;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 60;
    localparam int OW          = rpnc_pkg::OP_W;
    localparam int DW          = rpnc_pkg::DATA_W;
    localparam int SW          = rpnc_pkg::ST_W;
    localparam int PW          = rpnc_pkg::DEPTH_OUT_W;

    localparam logic [OW-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OW-1:0] OP_UNUSED_LAST  = 3'd7;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    typedef struct {
        logic [SW-1:0]        status;
        logic [PW-1:0]        depth;
        logic signed [DW-1:0] top_value;
    } t_calc_result;

    class stack_checker;
        logic signed [DW-1:0] entries [rpnc_pkg::DEPTH_DEF];
        int                   count;
        t_calc_result         awaited [$];
        int                   mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        function int depth_now();
            return count;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted command to the shadow stack and queue its result.
        function void note_command(logic [OW-1:0] op, logic signed [DW-1:0] value);
            t_calc_result         r;
            logic [SW-1:0]        st;
            logic signed [DW-1:0] res;
            longint               s;
            longint               t;
            longint               wide;
            st = rpnc_pkg::ST_OK;
            if (op == rpnc_pkg::OP_PUSH) begin
                if (count < rpnc_pkg::DEPTH_DEF) begin
                    entries[count] = value;
                    count++;
                end else begin
                    st = rpnc_pkg::ST_FULL;
                end
            end else if (op <= rpnc_pkg::OP_DIV) begin
                if (count == 0) begin
                    st = rpnc_pkg::ST_UNDER;
                end else if (count == 1) begin
                    // lone operand is consumed and lost
                    count = 0;
                    st    = rpnc_pkg::ST_UNDER;
                end else begin
                    t = entries[count-1];
                    s = entries[count-2];
                    count -= 2;
                    case (op)
                        rpnc_pkg::OP_ADD: wide = s + t;
                        rpnc_pkg::OP_SUB: wide = s - t;
                        rpnc_pkg::OP_MUL: wide = (s * t) >>> rpnc_pkg::FRAC_DEF;
                        default: wide = (t == 0) ? 64'sd0 : (s <<< rpnc_pkg::FRAC_DEF) / t;
                    endcase
                    if (op == rpnc_pkg::OP_DIV && t == 0) begin
                        st  = rpnc_pkg::ST_DIVZ;
                        res = (s > 0) ? rpnc_pkg::VAL_MAX
                            : (s < 0) ? rpnc_pkg::VAL_MIN : '0;
                    end else if (wide > Q_MAX) begin
                        st  = rpnc_pkg::ST_SAT;
                        res = rpnc_pkg::VAL_MAX;
                    end else if (wide < Q_MIN) begin
                        st  = rpnc_pkg::ST_SAT;
                        res = rpnc_pkg::VAL_MIN;
                    end else begin
                        res = wide[DW-1:0];
                    end
                    entries[count] = res;
                    count++;
                end
            end
            r.status    = st;
            r.depth     = PW'(count);
            r.top_value = (count > 0) ? entries[count-1] : '0;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [SW-1:0] status, logic [PW-1:0] depth,
                                   logic signed [DW-1:0] top_value);
            t_calc_result e;
            if (awaited.size() == 0) begin
                $error("result beat with none awaited: status %0d depth %0d top %0d",
                       status, depth, top_value);
                mismatches++;
                return;
            end
            e = awaited.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                mismatches++;
            end
            if (depth !== e.depth) begin
                $error("depth: expected %0d, got %0d", e.depth, depth);
                mismatches++;
            end
            if (top_value !== e.top_value) begin
                $error("top_value: expected %0d, got %0d", e.top_value, top_value);
                mismatches++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    rpnc_cmd_if    cmd_ch ();
    rpnc_res_if    res_ch ();
    stack_checker  sb;
    int            sent_count  = 0;
    int            idle_cycles = 0;
    bit            quiet       = 0;

    rpn_stack_calculator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    endfunction

    function automatic logic signed [DW-1:0] rand_q();
        case ($urandom_range(0, 9))
            0: return rpnc_pkg::VAL_MAX;
            1: return rpnc_pkg::VAL_MIN;
            2: return '0;
            3, 4, 5: return DW'(int'($urandom_range(0, 1048575)) - 524288);
            6, 7: return $urandom;
            8: return DW'(int'($urandom_range(0, 8)) - 4) <<< rpnc_pkg::FRAC_DEF;
            default: return DW'(int'($urandom_range(0, 131071)) - 65536);
        endcase
    endfunction

    // Keep the stack mostly between two and full, with some noise and misuse.
    function automatic logic [OW-1:0] pick_op(int depth);
        int roll = $urandom_range(0, 99);
        if (roll < 3)
            return OW'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        if (roll < 6 || (depth >= rpnc_pkg::DEPTH_DEF && roll < 90))
            return OW'($urandom_range(rpnc_pkg::OP_ADD, rpnc_pkg::OP_DIV));
        if (depth < 2 || roll < 50)
            return rpnc_pkg::OP_PUSH;
        return OW'($urandom_range(rpnc_pkg::OP_ADD, rpnc_pkg::OP_DIV));
    endfunction

    task automatic idle_cmd(input int cycles);
        cmd_ch.valid      <= 1'b0;
        cmd_ch.op         <= OW'($urandom);
        cmd_ch.push_value <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_cmd(input logic [OW-1:0] op, input logic signed [DW-1:0] value);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.push_value <= value;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sb.note_command(op, value);
        sent_count++;
        if (!quiet && $urandom_range(0, 3) == 0)
            idle_cmd(gap_len());
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Result side: random stalls, plus one long hold-off to back up the core.
    initial begin
        int stall_left = 0;
        bit held       = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sent_count >= HOLD_AT) begin
                held       = 1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left = gap_len() - 1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.status, res_ch.depth, res_ch.top_value);
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        sb = new();
        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.op         <= rpnc_pkg::OP_PUSH;
        cmd_ch.push_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty stack, then a lone operand
        send_cmd(rpnc_pkg::OP_ADD, '0);
        send_cmd(rpnc_pkg::OP_PUSH, rpnc_pkg::VAL_MAX);
        send_cmd(rpnc_pkg::OP_SUB, '0);
        // saturate high and low
        send_cmd(rpnc_pkg::OP_PUSH, rpnc_pkg::VAL_MAX);
        send_cmd(rpnc_pkg::OP_PUSH, 32'sh0001_0000);
        send_cmd(rpnc_pkg::OP_ADD, '1);
        send_cmd(rpnc_pkg::OP_PUSH, rpnc_pkg::VAL_MIN);
        send_cmd(rpnc_pkg::OP_MUL, '0);
        // divide by zero with negative, positive and zero dividend
        send_cmd(rpnc_pkg::OP_PUSH, '0);
        send_cmd(rpnc_pkg::OP_DIV, '0);
        send_cmd(rpnc_pkg::OP_PUSH, rpnc_pkg::VAL_MAX);
        send_cmd(rpnc_pkg::OP_SUB, '0);
        send_cmd(rpnc_pkg::OP_PUSH, rpnc_pkg::VAL_MAX);
        send_cmd(rpnc_pkg::OP_PUSH, '0);
        send_cmd(rpnc_pkg::OP_DIV, '0);
        send_cmd(rpnc_pkg::OP_PUSH, rpnc_pkg::VAL_MAX);
        send_cmd(rpnc_pkg::OP_PUSH, 32'sd1);
        send_cmd(rpnc_pkg::OP_DIV, '0);
        send_cmd(rpnc_pkg::OP_PUSH, '0);
        send_cmd(rpnc_pkg::OP_PUSH, '0);
        send_cmd(rpnc_pkg::OP_DIV, '0);
        // fill to the limit, then overflow it
        send_cmd(rpnc_pkg::OP_PUSH, rpnc_pkg::VAL_MIN);
        send_cmd(rpnc_pkg::OP_PUSH, -32'sd1);
        send_cmd(rpnc_pkg::OP_PUSH, 32'sh0001_8000);
        send_cmd(rpnc_pkg::OP_PUSH, 32'sh1234_5678);
        send_cmd(OP_UNUSED_FIRST, '0);
        send_cmd(OP_UNUSED_FIRST + 3'd1, '1);
        send_cmd(OP_UNUSED_LAST, '0);
        send_cmd(rpnc_pkg::OP_MUL, '0);
        drain_results();

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 200 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_CMDS / 2)
                drain_results();
            send_cmd(pick_op(sb.depth_now()), rand_q());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
